// ===== design/cse_pkg.sv =====
// ----------------------------------------------------------------------------
// cse_pkg
// Shared constants, types and helper functions of the contour cell segment
// extractor.
// ----------------------------------------------------------------------------
package cse_pkg;

  localparam int COORD_FRAC_BITS = 8;
  localparam int GRID_SIDE       = 4096;
  localparam int MAX_LEVELS      = 4;
  localparam int NUM_LEVEL_REGS  = 4;

  localparam int POS_W      = 12;
  localparam int SAMPLE_W   = 16;
  localparam int Z_W        = SAMPLE_W + 2;         // heights times four
  localparam int H_W        = Z_W;                  // |height difference|
  localparam int COORD_W    = 20;
  localparam int DELTA_W    = COORD_FRAC_BITS + 2;  // edge delta, +-one pixel
  localparam int Q_W        = COORD_FRAC_BITS;      // fraction quotient bits
  localparam int BITS_PER_STEP = 2;
  localparam int DIV_STEPS  = Q_W / BITS_PER_STEP;
  localparam int LI_W       = 2;
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int COORD_ONE  = 1 << COORD_FRAC_BITS;
  localparam int COORD_HALF = COORD_ONE >> 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_A   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_B   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_C   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_D   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVELS_IN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_FLAT = 3'd5;

  // vertex classes against a level
  localparam logic [1:0] SIDE_BELOW = 2'd0;
  localparam logic [1:0] SIDE_ON    = 2'd1;
  localparam logic [1:0] SIDE_ABOVE = 2'd2;

  // segment cases; I(p,q) is the interpolated crossing on edge p-q
  localparam logic [3:0] CASE_NONE    = 4'd0;
  localparam logic [3:0] CASE_AB      = 4'd1;
  localparam logic [3:0] CASE_BC      = 4'd2;
  localparam logic [3:0] CASE_CA      = 4'd3;
  localparam logic [3:0] CASE_A_IBC   = 4'd4;
  localparam logic [3:0] CASE_B_ICA   = 4'd5;
  localparam logic [3:0] CASE_C_IAB   = 4'd6;
  localparam logic [3:0] CASE_IAB_IBC = 4'd7;
  localparam logic [3:0] CASE_IBC_ICA = 4'd8;
  localparam logic [3:0] CASE_ICA_IAB = 4'd9;
  localparam logic [3:0] CASE_FLAT    = 4'd10;

  // indexed by side(A)*9 + side(B)*3 + side(C)
  localparam logic [3:0] CASE_TBL [27] = '{
    CASE_NONE,    CASE_NONE,  CASE_IBC_ICA,
    CASE_NONE,    CASE_BC,    CASE_B_ICA,
    CASE_IAB_IBC, CASE_C_IAB, CASE_ICA_IAB,
    CASE_NONE,    CASE_CA,    CASE_A_IBC,
    CASE_AB,      CASE_FLAT,  CASE_AB,
    CASE_A_IBC,   CASE_CA,    CASE_NONE,
    CASE_ICA_IAB, CASE_C_IAB, CASE_IAB_IBC,
    CASE_B_ICA,   CASE_BC,    CASE_NONE,
    CASE_IBC_ICA, CASE_NONE,  CASE_NONE
  };

  typedef struct packed {
    logic [COORD_W-1:0]    x;
    logic [COORD_W-1:0]    y;
    logic signed [Z_W-1:0] z;
  } vtx_t;

  // segment end: p + floor-ish(delta * a / s)
  typedef struct packed {
    logic [COORD_W-1:0]        x;
    logic [COORD_W-1:0]        y;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic [H_W-1:0]            a;
    logic [H_W-1:0]            s;
  } ep_t;

  typedef struct packed {
    logic [H_W-1:0] rem;
    logic [Q_W-1:0] q;
  } div_t;

  typedef struct packed {
    logic                  v;
    logic                  seg;
    logic                  fin;
    logic [LI_W-1:0]       li;
    logic signed [Z_W-1:0] lv;
    vtx_t                  a;
    vtx_t                  b;
    vtx_t                  c;
  } tri_t;

  typedef struct packed {
    logic            v;
    logic            seg;
    logic            fin;
    logic [LI_W-1:0] li;
    ep_t             s;
    ep_t             e;
    div_t            ds;
    div_t            de;
  } pipe_t;

  typedef struct packed {
    logic [LI_W-1:0]    li;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] ex;
    logic [COORD_W-1:0] ey;
  } seg_t;

  typedef struct packed {
    logic [NUM_LEVEL_REGS-1:0][SAMPLE_W-1:0] level;
    logic [CNT_W-1:0]                        n;
    logic                                    drop;
  } cfg_t;

  function automatic logic [1:0] side_of(logic signed [Z_W-1:0] z,
                                         logic signed [Z_W-1:0] lv);
    if (z > lv) return SIDE_ABOVE;
    if (z < lv) return SIDE_BELOW;
    return SIDE_ON;
  endfunction

  // one restoring division step, rem < s holds before and after
  function automatic div_t div_step(div_t d, logic [H_W-1:0] s);
    logic [H_W:0] t;
    div_t r;
    t = {d.rem, 1'b0};
    if (t >= {1'b0, s}) begin
      r.rem = H_W'(t - {1'b0, s});
      r.q   = {d.q[Q_W-2:0], 1'b1};
    end else begin
      r.rem = t[H_W-1:0];
      r.q   = {d.q[Q_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ===== design/cse_ifs.sv =====
// ----------------------------------------------------------------------------
// cse_ifs
// Valid/ready channels: grid cells in, contour segments out.
// ----------------------------------------------------------------------------
interface cse_cell_if import cse_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [POS_W-1:0]           cell_col;
  logic [POS_W-1:0]           cell_row;
  logic signed [SAMPLE_W-1:0] corner_tl;
  logic signed [SAMPLE_W-1:0] corner_tr;
  logic signed [SAMPLE_W-1:0] corner_br;
  logic signed [SAMPLE_W-1:0] corner_bl;

  modport source(output valid, cell_col, cell_row, corner_tl, corner_tr,
                 corner_br, corner_bl, input ready);
  modport sink(input valid, cell_col, cell_row, corner_tl, corner_tr,
               corner_br, corner_bl, output ready);
endinterface

interface cse_seg_if import cse_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LI_W-1:0]    level_index;
  logic [COORD_W-1:0] start_x;
  logic [COORD_W-1:0] start_y;
  logic [COORD_W-1:0] end_x;
  logic [COORD_W-1:0] end_y;
  logic               last_segment;

  modport source(output valid, level_index, start_x, start_y, end_x, end_y,
                 last_segment, input ready);
  modport sink(input valid, level_index, start_x, start_y, end_x, end_y,
               last_segment, output ready);
endinterface

// ===== design/cse_seq.sv =====
// ----------------------------------------------------------------------------
// cse_seq
// Cell capture and slot sequencer: one (level, triangle) slot per cycle while
// adv is high, then an end-of-cell slot (only that slot if the cell tests fail).
// ----------------------------------------------------------------------------
module cse_seq import cse_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  cse_cell_if.sink    in_ch,
  input  cfg_t        cfg,
  input  logic        adv,
  output tri_t        tri_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [LI_W-1:0] li_r, li_nxt;
  logic [1:0] tn_r, tn_nxt;
  tri_t tri_r, tri_nxt;

  logic [POS_W-1:0] col_r, row_r;
  logic [3:0][SAMPLE_W-1:0] smp_r;
  logic signed [SAMPLE_W-1:0] zmin_r, zmax_r;
  logic signed [Z_W-1:0] zsum_r;

  logic accept, issue, ok, in_rng, is_last;
  logic signed [SAMPLE_W-1:0] mn0, mn1, mx0, mx1, lvl, lv_last;
  logic [LI_W-1:0] li_top;
  logic [COORD_W-1:0] x0, x1, y0, y1;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign issue       = adv && (state_r != ST_IDLE);
  assign tri_o       = tri_r;

  always_comb begin
    mn0 = (in_ch.corner_tl < in_ch.corner_tr) ? in_ch.corner_tl : in_ch.corner_tr;
    mn1 = (in_ch.corner_br < in_ch.corner_bl) ? in_ch.corner_br : in_ch.corner_bl;
    mx0 = (in_ch.corner_tl > in_ch.corner_tr) ? in_ch.corner_tl : in_ch.corner_tr;
    mx1 = (in_ch.corner_br > in_ch.corner_bl) ? in_ch.corner_br : in_ch.corner_bl;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      col_r  <= in_ch.cell_col;
      row_r  <= in_ch.cell_row;
      smp_r  <= {in_ch.corner_bl, in_ch.corner_br, in_ch.corner_tr, in_ch.corner_tl};
      zmin_r <= (mn0 < mn1) ? mn0 : mn1;
      zmax_r <= (mx0 > mx1) ? mx0 : mx1;
      zsum_r <= Z_W'(in_ch.corner_tl) + Z_W'(in_ch.corner_tr)
              + Z_W'(in_ch.corner_br) + Z_W'(in_ch.corner_bl);
    end
  end

  function automatic vtx_t corner_of(logic [1:0] idx, logic [COORD_W-1:0] xl,
                                     logic [COORD_W-1:0] xh, logic [COORD_W-1:0] yl,
                                     logic [COORD_W-1:0] yh,
                                     logic [3:0][SAMPLE_W-1:0] smp);
    vtx_t r;
    r.z = {smp[idx], 2'b00};
    case (idx)
      2'd0:    begin r.x = xl; r.y = yl; end
      2'd1:    begin r.x = xh; r.y = yl; end
      2'd2:    begin r.x = xh; r.y = yh; end
      default: begin r.x = xl; r.y = yh; end
    endcase
    return r;
  endfunction

  always_comb begin
    li_top  = LI_W'(cfg.n - CNT_W'(1));
    lv_last = $signed(cfg.level[li_top]);
    ok = (cfg.n != '0)
      && ({1'b0, col_r} <= (POS_W + 1)'(GRID_SIDE - 2))
      && ({1'b0, row_r} <= (POS_W + 1)'(GRID_SIDE - 2))
      && (zmax_r >= $signed(cfg.level[0]))
      && (zmin_r <= lv_last);
    lvl     = $signed(cfg.level[li_r]);
    in_rng  = (lvl >= zmin_r) && (lvl <= zmax_r);
    is_last = (li_r == li_top) && (tn_r == 2'd3);

    x0 = {col_r, COORD_FRAC_BITS'(0)};
    y0 = {row_r, COORD_FRAC_BITS'(0)};
    x1 = {POS_W'(col_r + POS_W'(1)), COORD_FRAC_BITS'(0)};
    y1 = {POS_W'(row_r + POS_W'(1)), COORD_FRAC_BITS'(0)};

    tri_nxt = tri_r;
    if (adv) begin
      tri_nxt.v   = issue;
      tri_nxt.seg = (state_r == ST_RUN) && ok && in_rng;
      tri_nxt.fin = (state_r == ST_FIN) || ((state_r == ST_RUN) && !ok);
      tri_nxt.li  = li_r;
      tri_nxt.lv  = {lvl, 2'b00};
      tri_nxt.a   = corner_of(tn_r, x0, x1, y0, y1, smp_r);
      tri_nxt.c   = corner_of(2'(tn_r + 2'd1), x0, x1, y0, y1, smp_r);
      tri_nxt.b.x = x0 + COORD_W'(COORD_HALF);
      tri_nxt.b.y = y0 + COORD_W'(COORD_HALF);
      tri_nxt.b.z = zsum_r;
    end

    state_nxt = state_r;
    li_nxt    = li_r;
    tn_nxt    = tn_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RUN;
          li_nxt    = '0;
          tn_nxt    = '0;
        end
      end
      ST_RUN: begin
        if (issue) begin
          if (!ok) begin
            state_nxt = ST_IDLE;
          end else if (is_last) begin
            state_nxt = ST_FIN;
          end else begin
            tn_nxt = 2'(tn_r + 2'd1);
            if (tn_r == 2'd3) li_nxt = LI_W'(li_r + LI_W'(1));
          end
        end
      end
      ST_FIN: begin
        if (issue) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      li_r    <= '0;
      tn_r    <= '0;
      tri_r.v <= 1'b0;
    end else begin
      state_r <= state_nxt;
      li_r    <= li_nxt;
      tn_r    <= tn_nxt;
      tri_r   <= tri_nxt;
    end
  end

endmodule

// ===== design/cse_classify.sv =====
// ----------------------------------------------------------------------------
// cse_classify
// Classes the triangle vertices against the level, looks up the case and sets
// up both segment ends for the fraction divider.
// ----------------------------------------------------------------------------
module cse_classify import cse_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  tri_t  tri_i,
  input  logic  drop,
  input  logic  adv,
  output pipe_t p_o
);

  pipe_t p_r, p_nxt;
  logic [3:0] k;
  logic [1:0] sa, sb, sc;
  ep_t s_ep, e_ep;

  function automatic ep_t vtx_ep(vtx_t p);
    ep_t r;
    r.x  = p.x;
    r.y  = p.y;
    r.dx = '0;
    r.dy = '0;
    r.a  = '0;
    r.s  = H_W'(1);
    return r;
  endfunction

  // crossing on edge p-q; p and q lie strictly on opposite sides
  function automatic ep_t int_ep(vtx_t p, vtx_t q, logic signed [Z_W-1:0] lv);
    ep_t r;
    logic signed [Z_W:0] hp, dq;
    hp   = (Z_W + 1)'(p.z) - (Z_W + 1)'(lv);
    dq   = (Z_W + 1)'(q.z) - (Z_W + 1)'(p.z);
    r.x  = p.x;
    r.y  = p.y;
    r.dx = DELTA_W'(q.x - p.x);
    r.dy = DELTA_W'(q.y - p.y);
    r.a  = H_W'((hp < 0) ? -hp : hp);
    r.s  = H_W'((dq < 0) ? -dq : dq);
    return r;
  endfunction

  always_comb begin
    sa = side_of(tri_i.a.z, tri_i.lv);
    sb = side_of(tri_i.b.z, tri_i.lv);
    sc = side_of(tri_i.c.z, tri_i.lv);
    k  = CASE_TBL[5'(sa) * 5'd9 + 5'(sb) * 5'd3 + 5'(sc)];

    s_ep = vtx_ep(tri_i.a);
    e_ep = vtx_ep(tri_i.a);
    case (k)
      CASE_AB:      begin s_ep = vtx_ep(tri_i.a); e_ep = vtx_ep(tri_i.b); end
      CASE_BC:      begin s_ep = vtx_ep(tri_i.b); e_ep = vtx_ep(tri_i.c); end
      CASE_CA:      begin s_ep = vtx_ep(tri_i.c); e_ep = vtx_ep(tri_i.a); end
      CASE_A_IBC:   begin
        s_ep = vtx_ep(tri_i.a);
        e_ep = int_ep(tri_i.b, tri_i.c, tri_i.lv);
      end
      CASE_B_ICA:   begin
        s_ep = vtx_ep(tri_i.b);
        e_ep = int_ep(tri_i.c, tri_i.a, tri_i.lv);
      end
      CASE_C_IAB:   begin
        s_ep = vtx_ep(tri_i.c);
        e_ep = int_ep(tri_i.a, tri_i.b, tri_i.lv);
      end
      CASE_IAB_IBC: begin
        s_ep = int_ep(tri_i.a, tri_i.b, tri_i.lv);
        e_ep = int_ep(tri_i.b, tri_i.c, tri_i.lv);
      end
      CASE_IBC_ICA: begin
        s_ep = int_ep(tri_i.b, tri_i.c, tri_i.lv);
        e_ep = int_ep(tri_i.c, tri_i.a, tri_i.lv);
      end
      CASE_ICA_IAB: begin
        s_ep = int_ep(tri_i.c, tri_i.a, tri_i.lv);
        e_ep = int_ep(tri_i.a, tri_i.b, tri_i.lv);
      end
      CASE_FLAT:    begin s_ep = vtx_ep(tri_i.c); e_ep = vtx_ep(tri_i.a); end
      default:      begin s_ep = vtx_ep(tri_i.a); e_ep = vtx_ep(tri_i.a); end
    endcase

    p_nxt = p_r;
    if (adv) begin
      p_nxt.v      = tri_i.v;
      p_nxt.seg    = tri_i.seg && (k != CASE_NONE) && !((k == CASE_FLAT) && drop);
      p_nxt.fin    = tri_i.fin;
      p_nxt.li     = tri_i.li;
      p_nxt.s      = s_ep;
      p_nxt.e      = e_ep;
      p_nxt.ds.rem = s_ep.a;
      p_nxt.ds.q   = '0;
      p_nxt.de.rem = e_ep.a;
      p_nxt.de.q   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) p_r.v <= 1'b0;
    else        p_r   <= p_nxt;
  end

  assign p_o = p_r;

endmodule

// ===== design/cse_div_step.sv =====
// ----------------------------------------------------------------------------
// cse_div_step
// One register stage of the fraction divider: two quotient bits for both
// segment ends.
// ----------------------------------------------------------------------------
module cse_div_step import cse_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  pipe_t p_i,
  input  logic  adv,
  output pipe_t p_o
);

  pipe_t p_r, p_nxt;

  always_comb begin
    p_nxt = p_r;
    if (adv) begin
      p_nxt = p_i;
      for (int i = 0; i < BITS_PER_STEP; i++) begin
        p_nxt.ds = div_step(p_nxt.ds, p_i.s.s);
        p_nxt.de = div_step(p_nxt.de, p_i.e.s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) p_r.v <= 1'b0;
    else        p_r   <= p_nxt;
  end

  assign p_o = p_r;

endmodule

// ===== design/cse_emit.sv =====
// ----------------------------------------------------------------------------
// cse_emit
// Final coordinates, one-item hold-back to mark the last segment of a cell,
// and the output register. Owns the pipeline advance.
// ----------------------------------------------------------------------------
module cse_emit import cse_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  pipe_t    p_i,
  output logic     adv,
  cse_seg_if.source out_ch
);

  seg_t pend_r, pend_nxt, out_r, out_nxt, seg_new;
  logic pend_v_r, pend_v_nxt, out_v_r, out_v_nxt, out_last_r, out_last_nxt;

  // p + delta * a / s, rounded down (toward minus infinity)
  function automatic logic [COORD_W-1:0] fin_coord(logic [COORD_W-1:0] p,
                                                   logic signed [DELTA_W-1:0] d,
                                                   div_t dv);
    logic [DELTA_W-1:0] mag;
    logic [Q_W-1:0] fl;
    logic ex;
    mag = (d < 0) ? DELTA_W'(-d) : DELTA_W'(d);
    if (mag == DELTA_W'(COORD_ONE)) begin
      fl = dv.q;
      ex = (dv.rem == '0);
    end else if (mag == DELTA_W'(COORD_HALF)) begin
      fl = dv.q >> 1;
      ex = (dv.rem == '0) && !dv.q[0];
    end else begin
      fl = '0;
      ex = 1'b1;
    end
    if (d < 0) return p - COORD_W'(fl) - {{(COORD_W-1){1'b0}}, ~ex};
    return p + COORD_W'(fl);
  endfunction

  assign adv = !out_v_r || out_ch.ready;

  always_comb begin
    seg_new.li = p_i.li;
    seg_new.sx = fin_coord(p_i.s.x, p_i.s.dx, p_i.ds);
    seg_new.sy = fin_coord(p_i.s.y, p_i.s.dy, p_i.ds);
    seg_new.ex = fin_coord(p_i.e.x, p_i.e.dx, p_i.de);
    seg_new.ey = fin_coord(p_i.e.y, p_i.e.dy, p_i.de);

    pend_nxt     = pend_r;
    pend_v_nxt   = pend_v_r;
    out_nxt      = out_r;
    out_v_nxt    = out_v_r;
    out_last_nxt = out_last_r;
    if (adv) begin
      out_v_nxt = 1'b0;
      if (p_i.v && p_i.seg) begin
        if (pend_v_r) begin
          out_nxt      = pend_r;
          out_last_nxt = 1'b0;
          out_v_nxt    = 1'b1;
        end
        pend_nxt   = seg_new;
        pend_v_nxt = 1'b1;
      end else if (p_i.v && p_i.fin) begin
        // end of cell: the held segment is the last one
        if (pend_v_r) begin
          out_nxt      = pend_r;
          out_last_nxt = 1'b1;
          out_v_nxt    = 1'b1;
        end
        pend_v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.level_index  = out_r.li;
  assign out_ch.start_x      = out_r.sx;
  assign out_ch.start_y      = out_r.sy;
  assign out_ch.end_x        = out_r.ex;
  assign out_ch.end_y        = out_r.ey;
  assign out_ch.last_segment = out_last_r;

endmodule

// ===== design/contour_cell_segment_extractor.sv =====
// ----------------------------------------------------------------------------
// contour_cell_segment_extractor
// Contouring of one grid cell over four triangles around the cell centre.
// ----------------------------------------------------------------------------
// A cell is taken when the sequencer is idle, in a cycle of its own. A cell that
// passes the grid and level range tests then occupies the sequencer for one
// slot per active level and triangle plus an end slot; any other cell frees
// the sequencer after a single end slot. Slots then run through an 8-register
// pipeline (slot, classify, four divider stages of two fraction bits each,
// hold-back, output) at one slot per cycle, so segments leave at up to one per
// cycle. A stall on the output freezes the whole pipeline, sequencer included.
module contour_cell_segment_extractor import cse_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  cse_cell_if.sink              in_ch,
  cse_seg_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [NUM_LEVEL_REGS-1:0][SAMPLE_W-1:0] level_r;
  logic [CNT_W-1:0] lvl_use_r;
  logic drop_r;
  cfg_t cfg;
  logic adv;
  tri_t tri_s;
  pipe_t pipe_s [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r   <= '0;
      lvl_use_r <= CNT_W'(1);
      drop_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEVEL_A:   level_r[0] <= cfg_data[SAMPLE_W-1:0];
        CFG_LEVEL_B:   level_r[1] <= cfg_data[SAMPLE_W-1:0];
        CFG_LEVEL_C:   level_r[2] <= cfg_data[SAMPLE_W-1:0];
        CFG_LEVEL_D:   level_r[3] <= cfg_data[SAMPLE_W-1:0];
        CFG_LEVELS_IN: lvl_use_r  <= cfg_data[CNT_W-1:0];
        CFG_DROP_FLAT: drop_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.level = level_r;
    cfg.n     = (lvl_use_r > CNT_W'(MAX_LEVELS)) ? CNT_W'(MAX_LEVELS) : lvl_use_r;
    cfg.drop  = drop_r;
  end

  cse_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .cfg   (cfg),
    .adv   (adv),
    .tri_o (tri_s)
  );

  cse_classify u_classify (
    .clk   (clk),
    .rst_n (rst_n),
    .tri_i (tri_s),
    .drop  (cfg.drop),
    .adv   (adv),
    .p_o   (pipe_s[0])
  );

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    cse_div_step u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .p_i   (pipe_s[g]),
      .adv   (adv),
      .p_o   (pipe_s[g+1])
    );
  end

  cse_emit u_emit (
    .clk    (clk),
    .rst_n  (rst_n),
    .p_i    (pipe_s[DIV_STEPS]),
    .adv    (adv),
    .out_ch (out_ch)
  );

endmodule
